// ----- src/fixed_slot_pool_allocator_defines.svh -----
// Assertion macros shared by the checker of the slot pool allocator.
// No dependencies; included by files that hold concurrent assertions.
`ifndef FIXED_SLOT_POOL_ALLOCATOR_DEFINES_SVH
`define FIXED_SLOT_POOL_ALLOCATOR_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define FSPA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("fspa assertion failed");

// next-cycle implication, disabled while reset is low
`define FSPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("fspa assertion failed");

`endif

// ----- src/fspa_pkg.sv -----
// Types and codes of the fixed slot pool allocator.
// No dependencies; used by the interfaces, the top level and the checker.
`default_nettype none

package fspa_pkg;

    localparam int ADDR_W     = 32;
    localparam int STATUS_W   = 3;
    localparam int SLOT_NUM_W = 7;
    localparam int CFG_IDX_W  = 1;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_GRANTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FALLBACK = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FREED    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OUTSIDE  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FATAL    = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_POOL_ENABLED = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE    = 1'd1;

    typedef struct packed {
        logic              operation;
        logic [ADDR_W-1:0] request_size;
        logic [ADDR_W-1:0] release_address;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [ADDR_W-1:0]     slot_address;
        logic [SLOT_NUM_W-1:0] slot_number;
    } t_rsp;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [ADDR_W-1:0]    value;
    } t_cfg;

endpackage

`default_nettype wire

// ----- src/fspa_if.sv -----
// Valid/ready channels of the slot pool allocator: request, response, config.
// Depends on fspa_pkg for the word types.
`default_nettype none

interface fspa_req_if;
    import fspa_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface fspa_rsp_if;
    import fspa_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface fspa_cfg_if;
    import fspa_pkg::*;
    logic valid;
    logic ready;
    t_cfg data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- src/fixed_slot_pool_allocator.sv -----
// A request's response word is registered, valid in the cycle after acceptance.
// Throughput: one word per cycle unless the response stalls. Bitmap scan and
// update are combinational; the response register takes a new word as the last
// is taken. SLOT_BYTES must be a power of two, not enforced by the block itself.
// Synchronous reset clears busy bitmap, both config registers, response valid.
`default_nettype none

module fixed_slot_pool_allocator #(
    parameter int SLOT_COUNT        = 96,
    parameter int SLOT_BYTES        = 32768,
    parameter int MIN_REQUEST_BYTES = 16384
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    fspa_req_if.sink   i_req,
    fspa_rsp_if.source o_rsp,
    fspa_cfg_if.sink   i_cfg
);
    import fspa_pkg::*;

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int SHIFT = $clog2(SLOT_BYTES);
    localparam logic [ADDR_W:0] POOL_SPAN =
        (ADDR_W+1)'(longint'(SLOT_COUNT) * longint'(SLOT_BYTES));
    localparam logic [ADDR_W-1:0] MIN_SIZE  = ADDR_W'(MIN_REQUEST_BYTES);
    localparam logic [ADDR_W-1:0] MAX_SIZE  = ADDR_W'(SLOT_BYTES);

    logic                  r_pool_enabled;
    logic [ADDR_W-1:0]     r_pool_base;
    logic [SLOT_COUNT-1:0] r_busy;
    logic [SLOT_COUNT-1:0] n_busy;
    logic                  r_out_valid;
    t_rsp                  r_rsp;
    t_rsp                  n_rsp;

    logic                  accept;
    logic [ADDR_W-1:0]     fit_limit;
    logic [SLOT_COUNT-1:0] avail;
    logic                  found;
    logic [IDX_W-1:0]      pick;
    logic                  size_ok;
    logic [ADDR_W:0]       base_ext;
    logic [ADDR_W:0]       addr_ext;
    logic                  in_pool;
    logic [ADDR_W-1:0]     offset;
    logic [IDX_W-1:0]      rel_idx;
    logic                  aligned;

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_rsp;

    // slots whose start address fits in 32 bits, and the lowest free one
    always_comb begin
        fit_limit = (~r_pool_base) >> SHIFT;
        found     = 1'b0;
        pick      = '0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            avail[i] = !r_busy[i] && (ADDR_W'(i) <= fit_limit);
        end
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (avail[i]) begin
                found = 1'b1;
                pick  = IDX_W'(i);
            end
        end
    end

    always_comb begin
        size_ok  = (i_req.data.request_size >= MIN_SIZE) &&
                   (i_req.data.request_size <= MAX_SIZE);
        base_ext = {1'b0, r_pool_base};
        addr_ext = {1'b0, i_req.data.release_address};
        in_pool  = r_pool_enabled && (addr_ext >= base_ext) &&
                   (addr_ext < base_ext + POOL_SPAN);
        offset   = i_req.data.release_address - r_pool_base;
        rel_idx  = IDX_W'(offset >> SHIFT);
        aligned  = (offset[SHIFT-1:0] == '0);

        n_busy             = r_busy;
        n_rsp.status       = ST_FALLBACK;
        n_rsp.slot_address = '0;
        n_rsp.slot_number  = '0;
        if (i_req.data.operation == OP_ALLOC) begin
            if (r_pool_enabled && size_ok && found) begin
                n_busy[pick]       = 1'b1;
                n_rsp.status       = ST_GRANTED;
                n_rsp.slot_address = r_pool_base + (ADDR_W'(pick) << SHIFT);
                n_rsp.slot_number  = SLOT_NUM_W'(pick);
            end
        end else begin
            if (!in_pool) begin
                n_rsp.status = ST_OUTSIDE;
            end else if (aligned && r_busy[rel_idx]) begin
                n_busy[rel_idx]   = 1'b0;
                n_rsp.status      = ST_FREED;
                n_rsp.slot_number = SLOT_NUM_W'(rel_idx);
            end else begin
                n_rsp.status = ST_FATAL;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_enabled <= 1'b0;
            r_pool_base    <= '0;
            r_busy         <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.data.index)
                    CFG_POOL_ENABLED: r_pool_enabled <= i_cfg.data.value[0];
                    CFG_POOL_BASE:    r_pool_base    <= i_cfg.data.value;
                    default:          ;
                endcase
            end
            if (accept) begin
                r_busy      <= n_busy;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rsp <= n_rsp;
        end
    end

endmodule

`default_nettype wire

// ----- src/fspa_checker.sv -----
// Port-level assertions for the slot pool allocator, bound to the top level.
// Depends on fspa_pkg and fixed_slot_pool_allocator_defines.svh.
`default_nettype none
`include "fixed_slot_pool_allocator_defines.svh"

module fspa_checker (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 i_req_valid,
    input wire                 i_req_ready,
    input wire                 i_req_op,
    input wire                 i_rsp_valid,
    input wire                 i_rsp_ready,
    input wire fspa_pkg::t_rsp i_rsp_data
);
    import fspa_pkg::*;

    logic req_fire;
    logic rsp_stall;
    logic alloc_st;
    logic free_st;

    assign req_fire  = i_req_valid && i_req_ready;
    assign rsp_stall = i_rsp_valid && !i_rsp_ready;
    assign alloc_st  = (i_rsp_data.status == ST_GRANTED) ||
                       (i_rsp_data.status == ST_FALLBACK);
    assign free_st   = (i_rsp_data.status == ST_FREED) ||
                       (i_rsp_data.status == ST_OUTSIDE) ||
                       (i_rsp_data.status == ST_FATAL);

    `FSPA_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, rsp_stall, i_rsp_valid && $stable(i_rsp_data))
    `FSPA_ASSERT_NEXT(a_req_gives_rsp, i_clk, i_rst_n, req_fire, i_rsp_valid)
    `FSPA_ASSERT_NEXT(a_alloc_status, i_clk, i_rst_n, req_fire && (i_req_op == OP_ALLOC), alloc_st)
    `FSPA_ASSERT_NEXT(a_free_status, i_clk, i_rst_n, req_fire && (i_req_op == OP_FREE), free_st)

endmodule

bind fixed_slot_pool_allocator fspa_checker u_fspa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_req_op    (i_req.data.operation),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_data  (o_rsp.data)
);

`default_nettype wire

// ----- test/tb.sv -----
// Self-checking bench for the fixed slot pool allocator: a scoreboard class
// predicts every response word from the accepted request words and config.
// Depends on fspa_pkg, the fspa channel interfaces and the allocator top level.

module tb;
    import fspa_pkg::*;

    localparam int SLOT_COUNT  = 96;
    localparam int SLOT_BYTES  = 32768;
    localparam int MIN_BYTES   = 16384;
    localparam int PHASE_ITEMS = 104;
    localparam int QUIET_LIMIT = 4000;

    class slot_pool_scoreboard;
        bit                  enabled;
        logic [ADDR_W-1:0]   base;
        bit [SLOT_COUNT-1:0] busy;
        t_rsp                outcomes[$];
        int                  errors;

        function new();
            enabled = 1'b0;
            base    = '0;
            busy    = '0;
            errors  = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] value);
            if (idx == CFG_POOL_ENABLED) begin
                enabled = value[0];
            end else begin
                base = value;
            end
        endfunction

        function t_rsp settle_request(t_req r);
            t_rsp        res;
            logic [63:0] start;
            logic [63:0] base64;
            logic [63:0] addr64;
            logic [63:0] pool_end;
            logic [63:0] offset;
            logic [63:0] idx;
            bit          found;
            res    = '0;
            found  = 1'b0;
            base64 = {32'd0, base};
            if (r.operation == OP_ALLOC) begin
                res.status = ST_FALLBACK;
                if (enabled && r.request_size >= MIN_BYTES && r.request_size <= SLOT_BYTES) begin
                    for (int i = 0; i < SLOT_COUNT; i++) begin
                        start = base64 + 64'(i) * 64'(SLOT_BYTES);
                        if (!found && start <= 64'hFFFF_FFFF && !busy[i]) begin
                            busy[i]          = 1'b1;
                            found            = 1'b1;
                            res.status       = ST_GRANTED;
                            res.slot_address = start[ADDR_W-1:0];
                            res.slot_number  = 7'(i);
                        end
                    end
                end
            end else begin
                addr64   = {32'd0, r.release_address};
                pool_end = base64 + 64'(SLOT_COUNT) * 64'(SLOT_BYTES);
                if (!enabled || addr64 < base64 || addr64 >= pool_end) begin
                    res.status = ST_OUTSIDE;
                end else begin
                    offset = addr64 - base64;
                    idx    = offset / SLOT_BYTES;
                    if (offset % SLOT_BYTES == 0 && idx < SLOT_COUNT && busy[idx]) begin
                        busy[idx]       = 1'b0;
                        res.status      = ST_FREED;
                        res.slot_number = idx[SLOT_NUM_W-1:0];
                    end else begin
                        res.status = ST_FATAL;
                    end
                end
            end
            return res;
        endfunction

        function void note_request(t_req r);
            outcomes.push_back(settle_request(r));
        endfunction

        function int random_busy_slot();
            int taken[$];
            for (int i = 0; i < SLOT_COUNT; i++) begin
                if (busy[i]) taken.push_back(i);
            end
            if (taken.size() == 0) return -1;
            return taken[$urandom_range(taken.size() - 1)];
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_response(t_rsp got);
            t_rsp want;
            if (outcomes.size() == 0) begin
                report($sformatf("response word %h with nothing outstanding", got));
            end else begin
                want = outcomes.pop_front();
                if (got.status !== want.status)
                    report($sformatf("status %0d, want %0d", got.status, want.status));
                if (got.slot_address !== want.slot_address)
                    report($sformatf("slot_address %h, want %h",
                                     got.slot_address, want.slot_address));
                if (got.slot_number !== want.slot_number)
                    report($sformatf("slot_number %0d, want %0d",
                                     got.slot_number, want.slot_number));
            end
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   no_idle;

    slot_pool_scoreboard sb = new();

    fspa_req_if req_if ();
    fspa_rsp_if rsp_if ();
    fspa_cfg_if cfg_if ();

    fixed_slot_pool_allocator #(
        .SLOT_COUNT        (SLOT_COUNT),
        .SLOT_BYTES        (SLOT_BYTES),
        .MIN_REQUEST_BYTES (MIN_BYTES)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function int idle_len();
        int r;
        r = $urandom_range(99);
        if (r < 60) return 1;
        if (r < 92) return $urandom_range(4, 2);
        return $urandom_range(48, 12);
    endfunction

    function t_req alloc_req(logic [ADDR_W-1:0] size);
        t_req r;
        r.operation       = OP_ALLOC;
        r.request_size    = size;
        r.release_address = $urandom;
        return r;
    endfunction

    function t_req free_req(logic [ADDR_W-1:0] addr);
        t_req r;
        r.operation       = OP_FREE;
        r.request_size    = $urandom;
        r.release_address = addr;
        return r;
    endfunction

    function t_req next_item(int alloc_pct);
        t_req              r;
        int                slot;
        logic [ADDR_W-1:0] pool_end;
        r        = alloc_req($urandom);
        pool_end = sb.base + ADDR_W'(SLOT_COUNT * SLOT_BYTES);
        if ($urandom_range(99) < 80) begin
            slot = sb.random_busy_slot();
            if (slot < 0 || $urandom_range(99) < alloc_pct) begin
                r.request_size = $urandom_range(SLOT_BYTES, MIN_BYTES);
            end else begin
                r = free_req(sb.base + ADDR_W'(slot) * ADDR_W'(SLOT_BYTES));
            end
        end else begin
            case ($urandom_range(7))
                0: r = alloc_req($urandom);
                1: begin
                    case ($urandom_range(5))
                        0: r.request_size = '0;
                        1: r.request_size = MIN_BYTES - 1;
                        2: r.request_size = MIN_BYTES;
                        3: r.request_size = SLOT_BYTES;
                        4: r.request_size = SLOT_BYTES + 1;
                        default: r.request_size = '1;
                    endcase
                end
                2: r = free_req($urandom);
                3: r = free_req(sb.base + ADDR_W'($urandom_range(SLOT_COUNT - 1)) * SLOT_BYTES
                                + ADDR_W'($urandom_range(SLOT_BYTES - 1, 1)));
                4: r = free_req(sb.base + ADDR_W'($urandom_range(SLOT_COUNT - 1)) * SLOT_BYTES);
                5: r = free_req(sb.base - 1);
                6: r = free_req($urandom_range(1) ? pool_end : pool_end - 1);
                default: r = free_req(sb.base);
            endcase
        end
        return r;
    endfunction

    // entered and left just after a falling edge; valid stays high after a word
    task send_item(t_req r);
        int gap;
        gap = no_idle ? 0 : ($urandom_range(1) ? 0 : idle_len());
        if (gap > 0) begin
            req_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid = 1'b1;
        req_if.data  = r;
        do @(posedge i_clk); while (!req_if.ready);
        sb.note_request(r);
        @(negedge i_clk);
    endtask

    task settle();
        req_if.valid = 1'b0;
        while (sb.outcomes.size() != 0) @(negedge i_clk);
    endtask

    task write_reg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] value);
        t_cfg w;
        w.index      = idx;
        w.value      = value;
        cfg_if.valid = 1'b1;
        cfg_if.data  = w;
        do @(posedge i_clk); while (!cfg_if.ready);
        sb.set_reg(idx, value);
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    task configure(bit en, logic [ADDR_W-1:0] base);
        settle();
        write_reg(CFG_POOL_BASE, base);
        write_reg(CFG_POOL_ENABLED, ADDR_W'(en));
    endtask

    initial begin
        int hold;
        hold          = 0;
        rsp_if.ready  = 1'b0;
        forever begin
            @(negedge i_clk);
            if (no_idle) begin
                rsp_if.ready = 1'b1;
                hold         = 0;
            end else if (hold > 0) begin
                rsp_if.ready = 1'b0;
                hold--;
            end else begin
                rsp_if.ready = 1'b1;
                if ($urandom_range(3) == 0) hold = idle_len();
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) sb.check_response(rsp_if.data);
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
                (cfg_if.valid && cfg_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        bit                en;
        logic [ADDR_W-1:0] base;
        int                pct;
        bit                burst;
        i_rst_n      = 1'b0;
        no_idle      = 1'b0;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        cfg_if.valid = 1'b0;
        cfg_if.data  = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // pool absent after reset
        send_item(alloc_req(MIN_BYTES));
        send_item(free_req(32'd0));

        configure(1'b1, 32'h1000_0000);
        send_item(alloc_req(MIN_BYTES - 1));
        send_item(alloc_req(MIN_BYTES));
        send_item(alloc_req(SLOT_BYTES));
        send_item(alloc_req(SLOT_BYTES + 1));
        send_item(alloc_req(32'd0));
        send_item(alloc_req(32'hFFFF_FFFF));
        send_item(free_req(32'h1000_8000));
        send_item(free_req(32'h1000_8000));
        send_item(free_req(32'h1000_0001));
        send_item(free_req(32'h0FFF_FFFF));
        send_item(free_req(32'h1030_0000));
        send_item(free_req(32'h102F_FFFF));
        send_item(free_req(32'hFFFF_FFFF));
        send_item(alloc_req(20000));

        // only two slots fit below the top of the address space
        configure(1'b1, 32'hFFFF_0000);
        send_item(free_req(32'hFFFF_0000));
        send_item(free_req(32'hFFFF_8000));
        send_item(alloc_req(MIN_BYTES));
        send_item(alloc_req(SLOT_BYTES));
        send_item(alloc_req(MIN_BYTES));

        // disabled with busy slots left
        configure(1'b0, 32'hFFFF_0000);
        send_item(free_req(32'hFFFF_0000));

        for (int p = 0; p < 8; p++) begin
            burst = 1'b0;
            en    = 1'b1;
            case (p)
                0: begin
                    base  = 32'h0000_0000;
                    pct   = 95;
                    burst = 1'b1;
                end
                1: begin
                    base = 32'h0000_0000;
                    pct  = 20;
                end
                2: begin
                    base = 32'hFFFF_FFFF;
                    pct  = 50;
                end
                3: begin
                    en   = 1'b0;
                    base = $urandom;
                    pct  = 50;
                end
                4: begin
                    base = 32'hFFEC_0000;
                    pct  = 90;
                end
                5: begin
                    base = $urandom;
                    pct  = 40;
                end
                6: begin
                    base  = $urandom & ~(SLOT_BYTES - 1);
                    pct   = 60;
                    burst = 1'b1;
                end
                default: begin
                    base = 32'h8000_0000;
                    pct  = 30;
                end
            endcase
            configure(en, base);
            no_idle = burst;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(59) == 0) settle();
                send_item(next_item(pct));
            end
            no_idle = 1'b0;
        end

        settle();
        repeat (4) @(posedge i_clk);
        if (sb.errors == 0 && sb.outcomes.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+src
src/fspa_pkg.sv
src/fspa_if.sv
src/fixed_slot_pool_allocator.sv
src/fspa_checker.sv
test/tb.sv
